@@ design/bmle_pkg.sv @@
package bmle_pkg;

    localparam int unsigned CFG_W       = 17;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned IN_TUSER_W  = 4;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned Q_DEPTH     = 2;

    localparam logic        ACT_READ    = 1'b0;
    localparam logic        ACT_WRITE   = 1'b1;

    localparam logic [7:0]  FILL_BYTE   = 8'hA5;
    localparam logic [31:0] ROUND_MASK  = 32'hFFFF_FFF0;
    localparam logic [31:0] BYTE_SIGN   = 32'h0000_0080;
    localparam logic [31:0] BYTE_EXT    = 32'hFFFF_FF00;
    localparam logic [31:0] HALF_SIGN   = 32'h0000_8000;
    localparam logic [31:0] HALF_EXT    = 32'hFFFF_0000;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    // one classified access: ok[k] set when byte k is touched and in range
    typedef struct packed {
        logic        wr;
        t_size       size;
        logic        sx;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [3:0]  ok;
        logic [2:0]  bad;
    } t_cmd;

endpackage

@@ design/bmle_ram.sv @@
module bmle_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bmle_front.sv @@
module bmle_front #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bmle_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic [bmle_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmle_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_busy,
    input  logic                              i_q_full,
    output logic                              o_push,
    output bmle_pkg::t_cmd                    o_cmd
);
    import bmle_pkg::*;

    localparam int unsigned LIM_W   = $clog2(MEM_BYTES + 1);
    localparam logic [31:0] MEM_MAX = 32'(MEM_BYTES);
    localparam logic [31:0] LIM_RST = (MEM_BYTES < 65536) ? MEM_MAX : 32'd65536;

    logic [LIM_W-1:0] r_lim;
    logic [31:0]      w_round;
    logic [31:0]      n_lim;
    logic [31:0]      w_lim32;
    logic [1:0]       w_sz;
    logic [2:0]       w_nbytes;
    t_size            w_size;
    logic [3:0]       w_ok;
    logic [2:0]       w_bad;

    assign w_round = (32'(i_cfg_data) + 32'd15) & ROUND_MASK;
    assign n_lim   = (w_round > MEM_MAX) ? MEM_MAX : w_round;
    assign w_lim32 = 32'(r_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIM_W'(LIM_RST);
        end else if (i_cfg_valid) begin
            r_lim <= LIM_W'(n_lim);
        end
    end

    assign o_cfg_ready = 1'b1;

    // tuser: action, access_size, sign_extend
    assign w_sz = i_s_tuser[2:1];

    always_comb begin
        unique case (w_sz)
            SZ_BYTE: begin
                w_size   = SZ_BYTE;
                w_nbytes = 3'd1;
            end
            SZ_HALF: begin
                w_size   = SZ_HALF;
                w_nbytes = 3'd2;
            end
            default: begin
                w_size   = SZ_WORD;
                w_nbytes = 3'd4;
            end
        endcase
    end

    always_comb begin
        logic        touched;
        logic [31:0] a;
        w_ok  = '0;
        w_bad = '0;
        for (int k = 0; k < 4; k++) begin
            touched = (3'(k) < w_nbytes);
            a       = i_s_tdata[31:0] + 32'(k);
            w_ok[k] = touched && (a < w_lim32);
            w_bad   = w_bad + 3'(touched && !w_ok[k]);
        end
    end

    assign o_s_tready  = !i_busy && !i_q_full;
    assign o_push      = i_s_tvalid && o_s_tready;

    assign o_cmd.wr    = i_s_tuser[0];
    assign o_cmd.size  = w_size;
    assign o_cmd.sx    = i_s_tuser[3];
    assign o_cmd.addr  = i_s_tdata[31:0];
    assign o_cmd.wdata = i_s_tdata[63:32];
    assign o_cmd.ok    = w_ok;
    assign o_cmd.bad   = w_bad;

    a_lim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lim32 <= MEM_MAX)
        else $error("active size above memory size");

    a_byte_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> ($countones(o_cmd.ok) + int'(o_cmd.bad)) == int'(w_nbytes))
        else $error("good and bad bytes do not add up to access size");

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_busy |-> !o_push)
        else $error("word taken during clearing pass");

endmodule

@@ design/bmle_queue.sv @@
module bmle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmle_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output bmle_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import bmle_pkg::*;

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);

    t_cmd             r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(Q_DEPTH));
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("push into full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

@@ design/bmle_back.sv @@
module bmle_back #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bmle_pkg::t_cmd                    i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_busy,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bmle_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import bmle_pkg::*;

    localparam int unsigned ROWS  = (MEM_BYTES + 3) / 4;
    localparam int unsigned ROW_W = $clog2(ROWS);

    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    logic             issue;
    logic             s1_move;
    logic [7:0]       w_rdata [4];

    logic             r_s1_vld;
    logic             r_s1_wr;
    t_size            r_s1_size;
    logic             r_s1_sx;
    logic [1:0]       r_s1_lane;
    logic [3:0]       r_s1_ok;
    logic [2:0]       r_s1_bad;

    logic [31:0]      w_value;
    logic             r_out_vld;
    logic [31:0]      r_out_data;
    logic [2:0]       r_out_bad;

    // clearing pass fills every row with the reset pattern
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_busy  = r_clr_busy;
    assign s1_move = r_s1_vld && (!r_out_vld || i_m_tready);
    assign issue   = !i_empty && !r_clr_busy && (!r_s1_vld || s1_move);
    assign o_pop   = issue;

    // bank b holds bytes with address[1:0] == b; byte k of the access lands in
    // bank (addr + k) mod 4
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]       k_b;
        logic [31:0]      a_b;
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [7:0]       wdata;

        assign k_b   = 2'(b) - i_cmd.addr[1:0];
        assign a_b   = i_cmd.addr + 32'(k_b);
        assign we    = r_clr_busy || (issue && i_cmd.wr && i_cmd.ok[k_b]);
        assign waddr = r_clr_busy ? r_clr_row : a_b[ROW_W+1:2];
        assign wdata = r_clr_busy ? FILL_BYTE : i_cmd.wdata[{k_b, 3'b000} +: 8];

        bmle_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (issue && !i_cmd.wr),
            .i_raddr (a_b[ROW_W+1:2]),
            .o_rdata (w_rdata[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (issue) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_wr   <= i_cmd.wr;
            r_s1_size <= i_cmd.size;
            r_s1_sx   <= i_cmd.sx;
            r_s1_lane <= i_cmd.addr[1:0];
            r_s1_ok   <= i_cmd.ok;
            r_s1_bad  <= i_cmd.bad;
        end
    end

    // assemble little-endian value from the rotated bank outputs
    always_comb begin
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < 4; k++) begin
            v[8*k +: 8] = w_rdata[2'(r_s1_lane + 2'(k))] & {8{r_s1_ok[k]}};
        end
        if (r_s1_wr == ACT_WRITE) begin
            w_value = '0;
        end else if (r_s1_sx && r_s1_size == SZ_BYTE && (v & BYTE_SIGN) != '0) begin
            w_value = v | BYTE_EXT;
        end else if (r_s1_sx && r_s1_size == SZ_HALF && (v & HALF_SIGN) != '0) begin
            w_value = v | HALF_EXT;
        end else begin
            w_value = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= w_value;
            r_out_bad  <= r_s1_bad;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b0, r_out_bad, r_out_data};

    a_clr_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_vld && !o_pop)
        else $error("access issued during clearing pass");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_wr == ACT_WRITE) |=> (o_m_tdata[31:0] == '0))
        else $error("write word returned nonzero data");

    a_bad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[34:32] <= 3'd4))
        else $error("bad byte count above four");

endmodule

@@ design/byte_memory_le_access.sv @@
// channel   direction  signals                       contents
// s         in         i_s_tvalid/o_s_tready/tdata   tdata: address, write_data
//                                                    tuser: action, access_size, sign_extend
// m         out        o_m_tvalid/i_m_tready/tdata   tdata: read_data, bad_byte_count
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_data: size_limit
//
// sustained rate is one word per cycle while the output is not stalled; an accepted word
// passes the queue slot, the registered read of the four byte banks and the output register
// each access addresses one row in each of four byte-wide banks, one bank port per byte;
// writes enable only in-range bytes' banks; after reset a clearing pass fills the banks
// with 0xa5; o_s_tready stays low until it ends, cfg writes are taken at any time
// a stalled output backs up through the two-entry queue into o_s_tready
module byte_memory_le_access #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [31:0] address, [63:32] write_data
    input  logic [bmle_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] action, [2:1] access_size, [3] sign_extend
    input  logic [bmle_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] read_data, [34:32] bad_byte_count, [39:35] zero
    output logic [bmle_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bmle_pkg::CFG_W-1:0]        i_cfg_data
);
    import bmle_pkg::*;

    logic push;
    logic pop;
    logic busy;
    logic q_full;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    bmle_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_busy      (busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    bmle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bmle_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (queue_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_busy     (busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ tb/bmle_checker.sv @@
`timescale 1ns / 1ps

module bmle_checker #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // [31:0] address, [63:32] write_data
    input  logic [bmle_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] action, [2:1] access_size, [3] sign_extend
    input  logic [bmle_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] read_data, [34:32] bad_byte_count, [39:35] zero
    input  logic [bmle_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [bmle_pkg::CFG_W-1:0]       i_cfg_data,
    output int                               o_fail_cnt,
    output int                               o_pending,
    output int                               o_read_cnt,
    output int                               o_write_cnt,
    output int                               o_oob_cnt
);
    import bmle_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  bad_bytes;
    } t_access_result;

    logic [7:0]     mem_image [0:MEM_BYTES-1];
    int unsigned    active_limit;
    t_access_result expected_q [$];
    int             fail_cnt;
    int             read_cnt;
    int             write_cnt;
    int             oob_cnt;

    initial begin
        for (int i = 0; i < MEM_BYTES; i++) begin
            mem_image[i] = FILL_BYTE;
        end
        // reset size is 65536 bytes, capped by the memory size
        active_limit = (MEM_BYTES < 65536) ? MEM_BYTES : 65536;
        fail_cnt     = 0;
        read_cnt     = 0;
        write_cnt    = 0;
        oob_cnt      = 0;
    end

    function automatic int unsigned limit_from_cfg(logic [CFG_W-1:0] v);
        logic [31:0] rounded;
        rounded = (32'(v) + 32'd15) & ROUND_MASK;
        return (rounded > MEM_BYTES) ? MEM_BYTES : rounded;
    endfunction

    // performs one access on the image and returns what the block should answer
    function automatic t_access_result apply_access(logic wr, logic [1:0] sz, logic sx,
                                                    logic [31:0] addr, logic [31:0] wd);
        t_access_result r;
        int unsigned    nbytes;
        logic [31:0]    a;
        logic [31:0]    v;
        nbytes      = (sz == SZ_BYTE) ? 1 : (sz == SZ_HALF) ? 2 : 4;
        v           = '0;
        r.bad_bytes = '0;
        for (int unsigned k = 0; k < nbytes; k++) begin
            a = addr + k;
            if (a < active_limit) begin
                if (wr == ACT_WRITE) begin
                    mem_image[a] = wd[8*k +: 8];
                end else begin
                    v[8*k +: 8] = mem_image[a];
                end
            end else begin
                r.bad_bytes = r.bad_bytes + 3'd1;
            end
        end
        if (wr == ACT_WRITE) begin
            v = '0;
        end else if (sx) begin
            if (nbytes == 1 && (v & BYTE_SIGN) != 0) begin
                v = v | BYTE_EXT;
            end else if (nbytes == 2 && (v & HALF_SIGN) != 0) begin
                v = v | HALF_EXT;
            end
        end
        r.read_data = v;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("[%0t] error: %s expected 0x%08h got 0x%08h", $time, what, want, got);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                active_limit = limit_from_cfg(i_cfg_data);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.read_data = i_m_tdata[31:0];
                got.bad_bytes = i_m_tdata[34:32];
                if (expected_q.size() == 0) begin
                    flag_mismatch("word with no access pending, read_data", '0, got.read_data);
                end else begin
                    want = expected_q.pop_front();
                    if (got.read_data !== want.read_data) begin
                        flag_mismatch("read_data", want.read_data, got.read_data);
                    end
                    if (got.bad_bytes !== want.bad_bytes) begin
                        flag_mismatch("bad_byte_count", 32'(want.bad_bytes),
                                      32'(got.bad_bytes));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = apply_access(i_s_tuser[0], i_s_tuser[2:1], i_s_tuser[3],
                                    i_s_tdata[31:0], i_s_tdata[63:32]);
                expected_q.push_back(want);
                if (i_s_tuser[0] == ACT_WRITE) begin
                    write_cnt++;
                end else begin
                    read_cnt++;
                end
                if (want.bad_bytes != 0) begin
                    oob_cnt++;
                end
            end
        end
        o_pending   <= expected_q.size();
        o_fail_cnt  <= fail_cnt;
        o_read_cnt  <= read_cnt;
        o_write_cnt <= write_cnt;
        o_oob_cnt   <= oob_cnt;
    end

endmodule

@@ tb/byte_memory_le_access_tb.sv @@
`timescale 1ns / 1ps

module byte_memory_le_access_tb;
    import bmle_pkg::*;

    localparam int unsigned MEM_BYTES = 65536;
    localparam logic [1:0]  SZ_SPARE  = 2'd3;   // unused code, behaves as a word

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [IN_TUSER_W-1:0]  i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;

    int fail_cnt;
    int pending_cnt;
    int read_cnt;
    int write_cnt;
    int oob_cnt;

    bit tx_calm;
    bit rx_calm;
    bit hold_req;
    int size_settings;

    byte_memory_le_access #(
        .MEM_BYTES(MEM_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    bmle_checker #(
        .MEM_BYTES(MEM_BYTES)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending_cnt),
        .o_read_cnt  (read_cnt),
        .o_write_cnt (write_cnt),
        .o_oob_cnt   (oob_cnt)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("byte_memory_le_access: mismatch");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (63) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    function automatic int unsigned active_bytes(logic [CFG_W-1:0] v);
        logic [31:0] rounded;
        rounded = (32'(v) + 32'd15) & ROUND_MASK;
        return (rounded > MEM_BYTES) ? MEM_BYTES : rounded;
    endfunction

    task automatic send_access(logic wr, logic [1:0] sz, logic sx,
                               logic [31:0] addr, logic [31:0] wd);
        if (!tx_calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {wd, addr};
        i_s_tuser  = {sx, sz, wr};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_size_limit(logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        size_settings++;
    endtask

    // addresses cluster where the interesting boundaries are
    function automatic logic [31:0] pick_address(int unsigned lim);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            return $urandom_range(0, 63);
        end else if (sel < 50) begin
            return lim - 6 + $urandom_range(0, 11);
        end else if (sel < 60) begin
            return 32'hFFFF_FFF8 + $urandom_range(0, 7);
        end else if (sel < 70) begin
            return $urandom;
        end else if (sel < 80) begin
            return MEM_BYTES - 6 + $urandom_range(0, 11);
        end else if (lim > 0) begin
            return $urandom_range(0, lim - 1);
        end else begin
            return $urandom_range(0, 63);
        end
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom | 32'h0000_8080;
            default: return $urandom;
        endcase
    endfunction

    // mostly store-then-load pairs so reads see written data, the rest loose accesses
    task automatic run_random(int n, int unsigned lim);
        int          cnt;
        logic [31:0] addr;
        cnt = 0;
        while (cnt < n) begin
            addr = pick_address(lim);
            if ($urandom_range(0, 2) != 0) begin
                send_access(ACT_WRITE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            addr, pick_data());
                send_access(ACT_READ, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            addr + $urandom_range(0, 2), pick_data());
                cnt += 2;
            end else begin
                send_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), addr, pick_data());
                cnt++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        hold_req      = 1'b0;
        size_settings = 1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size, sign and alignment corners, wrap past the top of the address space
        send_access(ACT_WRITE, SZ_WORD, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(ACT_WRITE, SZ_WORD, 1'b1, 32'h0000_0004, 32'h0000_0000);
        send_access(ACT_WRITE, SZ_WORD, 1'b0, 32'h0000_0008, 32'h8001_7F80);
        send_access(ACT_READ,  SZ_BYTE, 1'b1, 32'h0000_0008, 32'h0000_0000);
        send_access(ACT_READ,  SZ_BYTE, 1'b0, 32'h0000_0008, 32'h0000_0000);
        send_access(ACT_READ,  SZ_HALF, 1'b1, 32'h0000_000A, 32'h0000_0000);
        send_access(ACT_READ,  SZ_HALF, 1'b0, 32'h0000_000A, 32'h0000_0000);
        send_access(ACT_READ,  SZ_WORD, 1'b1, 32'h0000_0008, 32'h0000_0000);
        send_access(ACT_WRITE, SZ_SPARE, 1'b0, 32'h0000_000D, 32'h1234_5678);
        send_access(ACT_READ,  SZ_SPARE, 1'b1, 32'h0000_000D, 32'hFFFF_FFFF);
        send_access(ACT_READ,  SZ_HALF, 1'b1, 32'h0000_000F, 32'h0000_0000);
        send_access(ACT_READ,  SZ_BYTE, 1'b1, 32'h0000_0009, 32'h0000_0000);
        send_access(ACT_WRITE, SZ_WORD, 1'b0, 32'hFFFF_FFFE, 32'hCAFE_F00D);
        send_access(ACT_READ,  SZ_WORD, 1'b0, 32'hFFFF_FFFE, 32'h0000_0000);
        send_access(ACT_READ,  SZ_WORD, 1'b0, 32'h0000_FFFD, 32'h0000_0000);
        send_access(ACT_WRITE, SZ_WORD, 1'b0, 32'h0000_FFFD, 32'hA1B2_C3D4);
        send_access(ACT_READ,  SZ_WORD, 1'b0, 32'h0000_FFFC, 32'h0000_0000);
        send_access(ACT_READ,  SZ_BYTE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_access(ACT_READ,  SZ_HALF, 1'b0, 32'h0001_0000, 32'h0000_0000);
        send_access(ACT_READ,  SZ_WORD, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_access(ACT_WRITE, SZ_BYTE, 1'b0, 32'h0000_FFFF, 32'hFFFF_FF7E);
        send_access(ACT_READ,  SZ_BYTE, 1'b1, 32'h0000_FFFF, 32'h0000_0000);
        send_access(ACT_WRITE, SZ_HALF, 1'b1, 32'h0000_0020, 32'h0000_8000);
        send_access(ACT_READ,  SZ_HALF, 1'b1, 32'h0000_0020, 32'h0000_0000);
        send_access(ACT_READ,  SZ_HALF, 1'b0, 32'h0000_0020, 32'h0000_0000);
        run_random(80, MEM_BYTES);

        // zero size: every byte out of range
        write_size_limit(17'd0);
        run_random(25, active_bytes(17'd0));

        write_size_limit(17'd1);
        run_random(50, active_bytes(17'd1));

        // long output hold-off while the sender keeps pushing
        write_size_limit(17'd17);
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        run_random(20, active_bytes(17'd17));
        tx_calm  = 1'b0;
        run_random(30, active_bytes(17'd17));

        // rounds past the memory and saturates
        write_size_limit(17'h1FFFF);
        run_random(60, active_bytes(17'h1FFFF));

        write_size_limit(17'd65521);
        run_random(40, active_bytes(17'd65521));

        write_size_limit(17'd100);
        run_random(50, active_bytes(17'd100));

        write_size_limit(17'd4095);
        run_random(40, active_bytes(17'd4095));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_random(60, active_bytes(17'd4095));

        wait_drained();
        $display("covered %0d accesses: %0d loads, %0d stores, %0d touching bytes out of range",
                 read_cnt + write_cnt, read_cnt, write_cnt, oob_cnt);
        $display("%0d memory sizes used, from zero bytes up to the saturated full size",
                 size_settings);
        if (fail_cnt == 0) begin
            $display("byte_memory_le_access: match");
        end else begin
            $display("byte_memory_le_access: mismatch");
        end
        $finish;
    end

endmodule
